// File: sv/tp_pkg.sv
// ----------------------------------------------------------------------------
// tp_pkg: shared types and constants
// Field structs, table geometry and the top-two merge for the path engine.
// ----------------------------------------------------------------------------
package tp_pkg;

	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 11;
	localparam int NODE_W    = 10;
	localparam int WT_W      = 30;
	localparam int JW_W      = WT_W + 1;
	localparam int DEPTH_W   = 11;
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int JA_W      = $clog2(MAX_NODES * LEVELS);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [WT_W-1:0]   weight;
	} item_t;

	typedef struct packed {
		logic [WT_W-1:0] delta;
		logic            found;
	} result_t;

	typedef struct packed {
		logic [JW_W-1:0] m1;
		logic [JW_W-1:0] m2;
	} pair_t;

	typedef struct packed {
		logic [NODE_W-1:0] anc;
		pair_t             w;
	} jrow_t;

	function automatic pair_t merge_top(pair_t a, pair_t b);
		pair_t r;
		r.m1 = (a.m1 > b.m1) ? a.m1 : b.m1;
		if (a.m1 == b.m1) begin
			r.m2 = (a.m2 > b.m2) ? a.m2 : b.m2;
		end else if (a.m1 > b.m1) begin
			r.m2 = (b.m1 > a.m2) ? b.m1 : a.m2;
		end else begin
			r.m2 = (a.m1 > b.m2) ? a.m1 : b.m2;
		end
		return r;
	endfunction

	function automatic logic [JA_W-1:0] jaddr(logic [NODE_W-1:0] n, logic [LVL_W-1:0] l);
		logic [JA_W-1:0] r;
		r = JA_W'(n) * JA_W'(LEVELS) + JA_W'(l);
		return r;
	endfunction

endpackage

// File: sv/tp_ram.sv
// ----------------------------------------------------------------------------
// tp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/tree_path_top_two_max_query.sv
// ----------------------------------------------------------------------------
// tree_path_top_two_max_query: binary-lifting path top-two maximum engine
// Load builds the lifting rows of a node; query climbs both ends to the LCA.
// Throughput: one transfer at a time; busy stays high until the result strobe.
// Loading node 0 returns its result in the cycle after the transfer.
// Each query level costs one jump-table read plus one depth read or a second jump read.
// Reset clears control only; tables are undefined until loaded, node 0 is fixed.
// ----------------------------------------------------------------------------
module tree_path_top_two_max_query (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tp_pkg::item_t    item,
	output logic             done,
	output tp_pkg::result_t  result
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_L0   = 5'd1;
	localparam logic [4:0] S_L1   = 5'd2;
	localparam logic [4:0] S_LR   = 5'd3;
	localparam logic [4:0] S_L2   = 5'd4;
	localparam logic [4:0] S_QDX  = 5'd5;
	localparam logic [4:0] S_QDY  = 5'd6;
	localparam logic [4:0] S_QSW  = 5'd7;
	localparam logic [4:0] S_P1A  = 5'd8;
	localparam logic [4:0] S_P1B  = 5'd9;
	localparam logic [4:0] S_P1C  = 5'd10;
	localparam logic [4:0] S_CHK  = 5'd11;
	localparam logic [4:0] S_P2A  = 5'd12;
	localparam logic [4:0] S_P2B  = 5'd13;
	localparam logic [4:0] S_P2C  = 5'd14;
	localparam logic [4:0] S_P3A  = 5'd15;
	localparam logic [4:0] S_P3B  = 5'd16;
	localparam logic [4:0] S_P3C  = 5'd17;
	localparam logic [4:0] S_FIN  = 5'd18;

	localparam logic [tp_pkg::LVL_W-1:0] LVL_TOP = tp_pkg::LVL_W'(tp_pkg::LEVELS - 1);

	logic [4:0]                   state_q;
	logic [tp_pkg::NODE_W-1:0]    x_q, y_q;
	logic [tp_pkg::WT_W-1:0]      w_q;
	logic [tp_pkg::LVL_W-1:0]     lvl_q;
	logic [tp_pkg::DEPTH_W-1:0]   dx_q, dy_q;
	tp_pkg::pair_t                m_q;
	tp_pkg::jrow_t                cur_q;
	tp_pkg::jrow_t                jx_q;
	logic                         jz_q, dz_q;
	logic                         done_q;
	tp_pkg::result_t              result_q;

	logic                         j_we;
	logic [tp_pkg::JA_W-1:0]      j_waddr, j_raddr;
	tp_pkg::jrow_t                j_wdata, j_rdata, jd;
	logic [tp_pkg::NODE_W-1:0]    j_rnode, d_rnode;
	logic [tp_pkg::LVL_W-1:0]     j_rlvl;
	logic                         d_we;
	logic [tp_pkg::NODE_W-1:0]    d_waddr;
	logic [tp_pkg::DEPTH_W-1:0]   d_wdata, d_rdata, dd;
	tp_pkg::pair_t                mrg_l, mrg_x, mrg_xy, mrg_f1, mrg_f2;
	logic [tp_pkg::JW_W-1:0]      w1, pick, pw;
	logic                         accept;

	tp_ram #(.WIDTH($bits(tp_pkg::jrow_t)), .DEPTH(tp_pkg::MAX_NODES * tp_pkg::LEVELS)) u_jump (
		.clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
		.raddr(j_raddr), .rdata(j_rdata)
	);

	tp_ram #(.WIDTH(tp_pkg::DEPTH_W), .DEPTH(tp_pkg::MAX_NODES)) u_depth (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_rnode), .rdata(d_rdata)
	);

	// node 0 is the sentinel: own ancestor, no weights, depth 0
	assign jd     = jz_q ? '0 : j_rdata;
	assign dd     = dz_q ? '0 : d_rdata;
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;
	assign j_raddr = tp_pkg::jaddr(j_rnode, j_rlvl);

	assign mrg_l  = tp_pkg::merge_top(cur_q.w, jd.w);
	assign mrg_x  = tp_pkg::merge_top(m_q, jx_q.w);
	assign mrg_xy = tp_pkg::merge_top(mrg_x, jd.w);
	assign mrg_f1 = tp_pkg::merge_top(m_q, '{m1: jx_q.w.m1, m2: '0});
	assign mrg_f2 = tp_pkg::merge_top(mrg_f1, '{m1: jd.w.m1, m2: '0});

	assign w1   = {1'b0, w_q} + tp_pkg::JW_W'(1);
	assign pick = (m_q.m1 == w1) ? m_q.m2 : m_q.m1;
	assign pw   = pick - tp_pkg::JW_W'(1);

	always_comb begin
		j_we    = 1'b0;
		j_waddr = tp_pkg::jaddr(x_q, lvl_q);
		j_wdata = cur_q;
		j_rnode = x_q;
		j_rlvl  = lvl_q;
		d_we    = 1'b0;
		d_waddr = x_q;
		d_wdata = dd + tp_pkg::DEPTH_W'(1);
		d_rnode = y_q;
		case (state_q)
			S_L0: begin
				j_we    = 1'b1;
				j_waddr = tp_pkg::jaddr(x_q, '0);
			end
			S_L1: begin
				d_we = 1'b1;
			end
			S_LR: begin
				j_rnode = cur_q.anc;
				j_rlvl  = lvl_q - tp_pkg::LVL_W'(1);
			end
			S_L2: begin
				j_we    = 1'b1;
				j_wdata = '{anc: jd.anc, w: mrg_l};
			end
			S_QDX: d_rnode = x_q;
			S_P1B: d_rnode = jd.anc;
			S_P2B: j_rnode = y_q;
			S_P3A: j_rlvl  = '0;
			S_P3B: begin
				j_rnode = y_q;
				j_rlvl  = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		jz_q <= (j_rnode == '0);
		dz_q <= (d_rnode == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.opcode == tp_pkg::OP_QUERY) begin
							state_q <= S_QDX;
						end else if (item.node_a == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_L0;
						end
					end
				end
				S_L0:  state_q <= S_L1;
				S_L1:  state_q <= S_LR;
				S_LR:  state_q <= S_L2;
				S_L2: begin
					if (lvl_q == LVL_TOP) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_LR;
					end
				end
				S_QDX: state_q <= S_QDY;
				S_QDY: state_q <= S_QSW;
				S_QSW: state_q <= S_P1A;
				S_P1A: state_q <= S_P1B;
				S_P1B: state_q <= S_P1C;
				S_P1C: state_q <= (lvl_q == '0) ? S_CHK : S_P1A;
				S_CHK: state_q <= (x_q == y_q) ? S_FIN : S_P2A;
				S_P2A: state_q <= S_P2B;
				S_P2B: state_q <= S_P2C;
				S_P2C: state_q <= (lvl_q == '0) ? S_P3A : S_P2A;
				S_P3A: state_q <= S_P3B;
				S_P3B: state_q <= S_P3C;
				S_P3C: state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q      <= item.node_a;
				y_q      <= item.node_b;
				w_q      <= item.weight;
				m_q      <= '0;
				lvl_q    <= tp_pkg::LVL_W'(1);
				cur_q    <= '{anc: item.node_b,
					w: '{m1: {1'b0, item.weight} + tp_pkg::JW_W'(1), m2: '0}};
				result_q <= '0;
			end
			S_L2: begin
				cur_q <= '{anc: jd.anc, w: mrg_l};
				lvl_q <= lvl_q + tp_pkg::LVL_W'(1);
			end
			S_QDY: dx_q <= dd;
			S_QSW: begin
				lvl_q <= LVL_TOP;
				if (dx_q < dd) begin
					x_q  <= y_q;
					y_q  <= x_q;
					dy_q <= dx_q;
				end else begin
					dy_q <= dd;
				end
			end
			S_P1B: jx_q <= jd;
			S_P1C: begin
				if (dd >= dy_q) begin
					m_q <= mrg_x;
					x_q <= jx_q.anc;
				end
				lvl_q <= lvl_q - tp_pkg::LVL_W'(1);
			end
			S_CHK: lvl_q <= LVL_TOP;
			S_P2B: jx_q <= jd;
			S_P2C: begin
				if (jx_q.anc != jd.anc) begin
					m_q <= mrg_xy;
					x_q <= jx_q.anc;
					y_q <= jd.anc;
				end
				lvl_q <= lvl_q - tp_pkg::LVL_W'(1);
			end
			S_P3B: jx_q <= jd;
			S_P3C: m_q <= mrg_f2;
			S_FIN: begin
				result_q.found <= (pick != '0);
				if (pick != '0 && {1'b0, w_q} >= pw) begin
					result_q.delta <= tp_pkg::WT_W'({1'b0, w_q} - pw);
				end else begin
					result_q.delta <= '0;
				end
			end
			default: ;
		endcase
	end

	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy dropped without result");

	a_accept_reacts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done)) else $error("transfer lost");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LR || state_q == S_P1A || state_q == S_P2A) |-> (lvl_q <= LVL_TOP))
		else $error("level out of range");

endmodule
